@@ hdl/nfp_pkg.sv @@
// Shared types, codes and constants of the Newton fractal pixel unit.
package nfp_pkg;

  localparam int MAX_ROOTS_DEF   = 8;
  localparam int MAX_COLOURS_DEF = 8;
  localparam int COORD_WIDTH_DEF = 48;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_ROOT   = 2'd1;
  localparam logic [1:0] OP_COLOUR = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ROOT_COUNT   = 3'd0;
  localparam logic [2:0] REG_COLOUR_COUNT = 3'd1;
  localparam logic [2:0] REG_ITER_LIMIT   = 3'd2;
  localparam logic [2:0] REG_FADE_STEPS   = 3'd3;
  localparam logic [2:0] REG_MIN_FADE     = 3'd4;
  localparam logic [2:0] REG_POWER        = 3'd5;
  localparam logic [2:0] REG_CYCLIC_MODE  = 3'd6;

  // Register reset values
  localparam logic [3:0]         RST_ROOT_COUNT   = 4'd1;
  localparam logic [3:0]         RST_COLOUR_COUNT = 4'd1;
  localparam logic [15:0]        RST_ITER_LIMIT   = 16'd256;
  localparam logic [15:0]        RST_FADE_STEPS   = 16'd16;
  localparam logic [16:0]        RST_MIN_FADE     = 17'd26214;
  localparam logic signed [23:0] RST_POWER        = 24'sd65536;
  localparam logic               RST_CYCLIC_MODE  = 1'b1;

  // Arithmetic constants
  localparam int MUL_W = 64;
  localparam int DIV_W = 128;
  localparam int M_W   = 97;
  localparam logic [47:0]    DIFF_LIMIT = {48{1'b1}};
  localparam logic [M_W-1:0] TOL_Q80    = 97'd120892581961463;
  localparam logic [53:0]    TERM_CAP   = {54{1'b1}};
  localparam logic [61:0]    STEP_CAP   = {62{1'b1}};
  localparam int TERM_SHIFT = 52;
  localparam int STEP_SHIFT = 68;

  typedef struct packed {
    logic [3:0]         root_count;
    logic [3:0]         colour_count;
    logic [15:0]        iteration_limit;
    logic [15:0]        fade_steps;
    logic [16:0]        min_fade;
    logic signed [23:0] power;
    logic               cyclic_mode;
  } cfg_t;

  typedef struct packed {
    logic [16:0] iterations;
    logic [2:0]  root_found;
    logic        converged;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } res_t;

endpackage

@@ hdl/nfp_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, stops when no bits remain.
module nfp_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [nfp_pkg::MUL_W-1:0]        a,
  input  logic [nfp_pkg::MUL_W-1:0]        b,
  output logic [2*nfp_pkg::MUL_W-1:0]      p,
  output logic                             busy,
  output logic                             done
);
  import nfp_pkg::*;

  logic [2*MUL_W-1:0] acc;
  logic [2*MUL_W-1:0] mcand;
  logic [MUL_W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mplier == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= (2*MUL_W)'(a);
      mplier <= b;
    end else if (busy && mplier != '0) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign p = acc;

endmodule

@@ hdl/nfp_div.sv @@
// Restoring divider, one quotient bit per cycle over the full numerator width.
module nfp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nfp_pkg::DIV_W-1:0]   num,
  input  logic [nfp_pkg::DIV_W-1:0]   den,
  output logic [nfp_pkg::DIV_W-1:0]   quo,
  output logic [nfp_pkg::DIV_W-1:0]   rem,
  output logic                        busy,
  output logic                        done
);
  import nfp_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [CW-1:0]  cnt;
  logic [DIV_W:0] trial;
  logic           fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

@@ hdl/nfp_core.sv @@
// Table memories and the sequencer that runs Newton steps, colour choice and fade.
module nfp_core #(
  parameter int MAX_ROOTS   = nfp_pkg::MAX_ROOTS_DEF,
  parameter int MAX_COLOURS = nfp_pkg::MAX_COLOURS_DEF,
  parameter int COORD_WIDTH = nfp_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  nfp_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [2:0]              in_slot,
  input  logic [COORD_WIDTH-1:0]  in_real,
  input  logic [COORD_WIDTH-1:0]  in_imag,
  input  logic [26:0]             in_colour,
  output logic                    res_valid,
  input  logic                    res_ready,
  output nfp_pkg::res_t           res
);
  import nfp_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int RA   = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
  localparam int CA   = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
  localparam int KW   = $clog2(MAX_ROOTS + 1);
  localparam int CCW  = $clog2(MAX_COLOURS + 1);
  localparam int XW   = (KW > CCW) ? KW : CCW;
  localparam int DW   = (CW + 1 > 50) ? CW + 1 : 50;
  localparam int SW   = ((CW > 63) ? CW : 63) + 2;
  localparam int DR_W = 55 + KW;
  localparam int Q_W  = 2 * (DR_W - 1) + 1;

  typedef enum logic [25:0] {
    S_IDLE  = 26'd1 << 0,  S_ITER = 26'd1 << 1,  S_RD   = 26'd1 << 2,
    S_DIFF  = 26'd1 << 3,  S_MUU  = 26'd1 << 4,  S_MVV  = 26'd1 << 5,
    S_MPU   = 26'd1 << 6,  S_DVU  = 26'd1 << 7,  S_MPV  = 26'd1 << 8,
    S_DVV   = 26'd1 << 9,  S_QR   = 26'd1 << 10, S_QI   = 26'd1 << 11,
    S_SR    = 26'd1 << 12, S_SI   = 26'd1 << 13, S_COL  = 26'd1 << 14,
    S_FMOD  = 26'd1 << 15, S_FCYC = 26'd1 << 16, S_FBASE = 26'd1 << 17,
    S_FBIT  = 26'd1 << 18, S_FMG  = 26'd1 << 19, S_FSQ  = 26'd1 << 20,
    S_LIFT  = 26'd1 << 21, S_CR   = 26'd1 << 22, S_CG   = 26'd1 << 23,
    S_CB    = 26'd1 << 24, S_DONE = 26'd1 << 25
  } state_t;

  state_t state;

  // Table memories
  logic [2*CW-1:0] root_mem [MAX_ROOTS];
  logic [26:0]     col_mem  [MAX_COLOURS];
  logic [2*CW-1:0] root_q;
  logic [26:0]     col_q;
  logic            ld_root, ld_col, rd_root, rd_col;

  // Working registers
  logic signed [CW-1:0]   zr, zi;
  logic [16:0]            count;
  logic                   conv;
  logic [KW-1:0]          k;
  logic [XW-1:0]          cidx;
  logic [47:0]            umag, vmag;
  logic                   uneg, vneg;
  logic [M_W-1:0]         m;
  logic signed [DR_W-1:0] dr, di;
  logic [Q_W-1:0]         q;
  logic [15:0]            rmod;
  logic [16:0]            nexp;
  logic [31:0]            base;
  logic [32:0]            g;
  logic [7:0]             red, green, blue;
  logic                   pend;

  // Arithmetic units
  logic                 mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic                 div_start, div_busy, div_done;
  logic [DIV_W-1:0]     div_num, div_den, div_quo, div_rem;
  logic                 mul_st, div_st, op_done;

  // Derived configuration
  logic [KW-1:0]  rc;
  logic [CCW-1:0] cc;
  logic [15:0]    fsteps;
  logic [16:0]    mf;
  logic [23:0]    pm;
  logic           pneg;

  // Combinational helpers
  logic signed [DW-1:0] du, dv;
  logic [48:0]          uclamp, vclamp;
  logic [DR_W-1:0]      drm, dim;
  logic [M_W-1:0]       m_sum;
  logic [Q_W-1:0]       q_sum;
  logic [53:0]          tmag;
  logic [61:0]          wmag;
  logic [39:0]          s;
  logic [7:0]           chan;
  logic [KW-1:0]        k_inc;
  logic [16:0]          count_inc;

  function automatic logic [48:0] clamp_mag(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] lim;
    logic [DW-1:0]        a;
    lim = $signed(DW'(DIFF_LIMIT));
    a = d[DW-1] ? DW'(-d) : DW'(d);
    if (d > lim) return {1'b0, DIFF_LIMIT};
    if (d < -lim) return {1'b1, DIFF_LIMIT};
    return {d[DW-1], a[47:0]};
  endfunction

  function automatic logic signed [CW-1:0] step_sat(input logic signed [CW-1:0] z,
                                                    input logic [61:0] w,
                                                    input logic wneg);
    logic signed [SW-1:0] ws;
    logic signed [SW-1:0] r;
    logic                 ok;
    ws = $signed(SW'(w));
    r = wneg ? SW'(z) + ws : SW'(z) - ws;
    ok = (&r[SW-1:CW-1]) || !(|r[SW-1:CW-1]);
    if (ok) return r[CW-1:0];
    return r[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  always_comb begin
    if (8'(cfg.root_count) > 8'(MAX_ROOTS)) rc = KW'(MAX_ROOTS);
    else rc = KW'(cfg.root_count);
    if (8'(cfg.colour_count) > 8'(MAX_COLOURS)) cc = CCW'(MAX_COLOURS);
    else if (cfg.colour_count == 4'd0) cc = CCW'(1);
    else cc = CCW'(cfg.colour_count);
    fsteps = (cfg.fade_steps == 16'd0) ? 16'd1 : cfg.fade_steps;
    mf     = (cfg.min_fade > 17'd65536) ? 17'd65536 : cfg.min_fade;
    pneg   = cfg.power[23];
    pm     = pneg ? 24'(-cfg.power) : 24'(cfg.power);
  end

  always_comb begin
    du     = DW'($signed(zr)) - DW'($signed(root_q[CW-1:0]));
    dv     = DW'($signed(zi)) - DW'($signed(root_q[2*CW-1:CW]));
    uclamp = clamp_mag(du);
    vclamp = clamp_mag(dv);
    drm    = dr[DR_W-1] ? DR_W'(-dr) : DR_W'(dr);
    dim    = di[DR_W-1] ? DR_W'(-di) : DR_W'(di);
    m_sum  = m + M_W'(mul_p);
    q_sum  = q + Q_W'(mul_p);
    tmag   = (div_quo > DIV_W'(TERM_CAP)) ? TERM_CAP : div_quo[53:0];
    wmag   = (div_quo > DIV_W'(STEP_CAP)) ? STEP_CAP : div_quo[61:0];
    s      = (g > 33'(255 << 24)) ? 40'(255) << 32 : 40'(g) << 8;
    chan   = (mul_p[48:40] > 9'd255) ? 8'd255 : mul_p[47:40];
    k_inc  = k + 1'b1;
    count_inc = count + 1'b1;
  end

  // Unit operand selection by step
  always_comb begin
    mul_st = state inside {S_MUU, S_MVV, S_MPU, S_MPV, S_QR, S_QI, S_FMG, S_FSQ,
                           S_LIFT, S_CR, S_CG, S_CB};
    div_st = state inside {S_DVU, S_DVV, S_SR, S_SI, S_FMOD, S_FCYC, S_FBASE};
    mul_a = '0;
    mul_b = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      S_MUU:   begin mul_a = MUL_W'(umag); mul_b = MUL_W'(umag); end
      S_MVV:   begin mul_a = MUL_W'(vmag); mul_b = MUL_W'(vmag); end
      S_MPU:   begin mul_a = MUL_W'(pm); mul_b = MUL_W'(umag); end
      S_MPV:   begin mul_a = MUL_W'(pm); mul_b = MUL_W'(vmag); end
      S_QR:    begin mul_a = MUL_W'(drm); mul_b = MUL_W'(drm); end
      S_QI:    begin mul_a = MUL_W'(dim); mul_b = MUL_W'(dim); end
      S_FMG:   begin mul_a = MUL_W'(g); mul_b = MUL_W'(base); end
      S_FSQ:   begin mul_a = MUL_W'(base); mul_b = MUL_W'(base); end
      S_LIFT:  begin mul_a = MUL_W'(17'd65536 - mf); mul_b = MUL_W'(g); end
      S_CR:    begin mul_a = MUL_W'(col_q[8:0]); mul_b = MUL_W'(s); end
      S_CG:    begin mul_a = MUL_W'(col_q[17:9]); mul_b = MUL_W'(s); end
      S_CB:    begin mul_a = MUL_W'(col_q[26:18]); mul_b = MUL_W'(s); end
      S_DVU, S_DVV: begin
        div_num = DIV_W'(mul_p) << TERM_SHIFT;
        div_den = DIV_W'(m);
      end
      S_SR:    begin div_num = DIV_W'(drm) << STEP_SHIFT; div_den = DIV_W'(q); end
      S_SI:    begin div_num = DIV_W'(dim) << STEP_SHIFT; div_den = DIV_W'(q); end
      S_FMOD:  begin div_num = DIV_W'(count); div_den = DIV_W'(fsteps); end
      S_FCYC:  begin
        div_num = DIV_W'(fsteps - rmod) << 32;
        div_den = DIV_W'(fsteps);
      end
      S_FBASE: begin
        div_num = DIV_W'(fsteps - 16'd1) << 32;
        div_den = DIV_W'(fsteps);
      end
      default: ;
    endcase
    mul_start = mul_st && !pend;
    div_start = div_st && !pend;
    op_done   = pend && (mul_done || div_done);
  end

  nfp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .p(mul_p), .busy(mul_busy), .done(mul_done)
  );

  nfp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .rem(div_rem), .busy(div_busy), .done(div_done)
  );

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign ld_root = in_valid && in_ready && in_op == OP_ROOT && 7'(in_slot) < 7'(MAX_ROOTS);
  assign ld_col  = in_valid && in_ready && in_op == OP_COLOUR &&
                   7'(in_slot) < 7'(MAX_COLOURS);
  assign rd_root = (state == S_RD);
  assign rd_col  = (state == S_COL) && (CCW'(cidx) < cc) && (XW'(cc) > cidx);

  always_ff @(posedge clk) begin
    if (ld_root) root_mem[RA'(in_slot)] <= {in_imag, in_real};
    if (rd_root) root_q <= root_mem[RA'(k)];
  end

  always_ff @(posedge clk) begin
    if (ld_col) col_mem[CA'(in_slot)] <= in_colour;
    if (rd_col) col_q <= col_mem[CA'(cidx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (mul_start || div_start) begin
      pend <= 1'b1;
    end else if (op_done) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_op == OP_POINT) begin
            zr    <= $signed(in_real);
            zi    <= $signed(in_imag);
            count <= '0;
            conv  <= 1'b0;
            state <= S_ITER;
          end
        end
        S_ITER: begin
          dr <= '0;
          di <= '0;
          k  <= '0;
          state <= (rc == '0) ? S_QR : S_RD;
        end
        S_RD: state <= S_DIFF;
        S_DIFF: begin
          uneg <= uclamp[48];
          umag <= uclamp[47:0];
          vneg <= vclamp[48];
          vmag <= vclamp[47:0];
          state <= S_MUU;
        end
        S_MUU: if (op_done) begin
          m <= M_W'(mul_p);
          state <= S_MVV;
        end
        S_MVV: if (op_done) begin
          m <= m_sum;
          if (m_sum < TOL_Q80) begin
            conv  <= 1'b1;
            cidx  <= XW'(k);
            state <= S_COL;
          end else begin
            state <= S_MPU;
          end
        end
        S_MPU: if (op_done) state <= S_DVU;
        S_DVU: if (op_done) begin
          dr <= (pneg ^ uneg) ? dr - $signed(DR_W'(tmag)) : dr + $signed(DR_W'(tmag));
          state <= S_MPV;
        end
        S_MPV: if (op_done) state <= S_DVV;
        S_DVV: if (op_done) begin
          di <= (pneg ^ vneg) ? di + $signed(DR_W'(tmag)) : di - $signed(DR_W'(tmag));
          k  <= k_inc;
          state <= (k_inc < rc) ? S_RD : S_QR;
        end
        S_QR: if (op_done) begin
          q <= Q_W'(mul_p);
          state <= S_QI;
        end
        S_QI: if (op_done) begin
          q <= q_sum;
          if (q_sum == '0) begin
            // zero divisor: fail at once
            count <= 17'(cfg.iteration_limit) + 17'd1;
            cidx  <= XW'(cc - 1'b1);
            state <= S_COL;
          end else begin
            state <= S_SR;
          end
        end
        S_SR: if (op_done) begin
          zr <= step_sat(zr, wmag, dr[DR_W-1]);
          state <= S_SI;
        end
        S_SI: if (op_done) begin
          zi <= step_sat(zi, wmag, !di[DR_W-1] && di != '0);
          count <= count_inc;
          if (count_inc > 17'(cfg.iteration_limit)) begin
            cidx  <= XW'(cc - 1'b1);
            state <= S_COL;
          end else begin
            state <= S_ITER;
          end
        end
        S_COL: begin
          // reduce the index modulo the colour count, then read the entry
          if (cidx >= XW'(cc)) cidx <= cidx - XW'(cc);
          else state <= cfg.cyclic_mode ? S_FMOD : S_FBASE;
        end
        S_FMOD: if (op_done) begin
          rmod  <= div_rem[15:0];
          state <= S_FCYC;
        end
        S_FCYC: if (op_done) begin
          g     <= div_quo[32:0];
          state <= S_LIFT;
        end
        S_FBASE: if (op_done) begin
          base  <= div_quo[31:0];
          g     <= 33'h1_0000_0000;
          nexp  <= count;
          state <= S_FBIT;
        end
        S_FBIT: begin
          if (nexp == '0) state <= S_LIFT;
          else if (nexp[0]) state <= S_FMG;
          else state <= S_FSQ;
        end
        S_FMG: if (op_done) begin
          g     <= mul_p[64:32];
          state <= S_FSQ;
        end
        S_FSQ: if (op_done) begin
          base  <= mul_p[63:32];
          nexp  <= nexp >> 1;
          state <= S_FBIT;
        end
        S_LIFT: if (op_done) begin
          g     <= 33'({mf, 16'd0}) + 33'(mul_p >> 16);
          state <= S_CR;
        end
        S_CR: if (op_done) begin
          red   <= chan;
          state <= S_CG;
        end
        S_CG: if (op_done) begin
          green <= chan;
          state <= S_CB;
        end
        S_CB: if (op_done) begin
          blue  <= chan;
          state <= S_DONE;
        end
        S_DONE: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.red        = red;
    res.green      = green;
    res.blue       = blue;
    res.converged  = conv;
    res.root_found = conv ? 3'(k) : 3'd0;
    res.iterations = count;
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_busy && div_busy))
    else $error("multiplier and divider running together");

  a_pend_unit: assert property (@(posedge clk) disable iff (rst)
    pend |-> (mul_busy || div_busy || mul_done || div_done))
    else $error("operation pending with no unit at work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count <= 17'(cfg.iteration_limit) + 17'd1))
    else $error("step count beyond limit plus one");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && conv) |-> (count <= 17'(cfg.iteration_limit)))
    else $error("converged point reports count above limit");

  a_root_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (k < rc))
    else $error("root read beyond roots in use");

endmodule

@@ hdl/newton_fractal_pixel_unit.sv @@
// Newton fractal pixel unit: register port, input stream, result register.
//
//  channel  | direction | transaction
//  s_*      | in        | tuser op; tdata slot, point real/imag, colour weights
//  m_*      | out       | tdata red, green, blue, converged, root_found, iterations
//  apb      | in/out    | register write or read, pready always high
//
// A point runs Newton steps, each with work for every root in use on the
// bit-serial multiplier and the 128-bit restoring divider, which sets most of a step's time.
// Colour and fade follow the last step. One item is in work at a time; the
// result register lets the next item in while a result waits. Reset is
// synchronous and clears control state only.
module newton_fractal_pixel_unit #(
  parameter int MAX_ROOTS   = nfp_pkg::MAX_ROOTS_DEF,
  parameter int MAX_COLOURS = nfp_pkg::MAX_COLOURS_DEF,
  parameter int COORD_WIDTH = nfp_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot, point_real, point_imag, colour_red, colour_green, colour_blue
  input  logic [((2*COORD_WIDTH+30+7)/8)*8-1:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red, green, blue, converged, root_found, iterations
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nfp_pkg::*;

  localparam int CW = COORD_WIDTH;

  cfg_t       cfg;
  res_t       res, out_res;
  logic       res_valid, res_ready;
  logic       wr_en;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_count      <= RST_ROOT_COUNT;
      cfg.colour_count    <= RST_COLOUR_COUNT;
      cfg.iteration_limit <= RST_ITER_LIMIT;
      cfg.fade_steps      <= RST_FADE_STEPS;
      cfg.min_fade        <= RST_MIN_FADE;
      cfg.power           <= RST_POWER;
      cfg.cyclic_mode     <= RST_CYCLIC_MODE;
    end else if (wr_en) begin
      case (ridx)
        REG_ROOT_COUNT:   cfg.root_count      <= pwdata[3:0];
        REG_COLOUR_COUNT: cfg.colour_count    <= pwdata[3:0];
        REG_ITER_LIMIT:   cfg.iteration_limit <= pwdata[15:0];
        REG_FADE_STEPS:   cfg.fade_steps      <= pwdata[15:0];
        REG_MIN_FADE:     cfg.min_fade        <= pwdata[16:0];
        REG_POWER:        cfg.power           <= $signed(pwdata[23:0]);
        REG_CYCLIC_MODE:  cfg.cyclic_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ROOT_COUNT:   prdata = 32'(cfg.root_count);
      REG_COLOUR_COUNT: prdata = 32'(cfg.colour_count);
      REG_ITER_LIMIT:   prdata = 32'(cfg.iteration_limit);
      REG_FADE_STEPS:   prdata = 32'(cfg.fade_steps);
      REG_MIN_FADE:     prdata = 32'(cfg.min_fade);
      REG_POWER:        prdata = 32'(cfg.power);
      REG_CYCLIC_MODE:  prdata = 32'(cfg.cyclic_mode);
      default:          prdata = '0;
    endcase
  end

  nfp_core #(
    .MAX_ROOTS(MAX_ROOTS), .MAX_COLOURS(MAX_COLOURS), .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_op(s_tuser),
    .in_slot(s_tdata[2:0]),
    .in_real(s_tdata[3 +: CW]),
    .in_imag(s_tdata[3+CW +: CW]),
    .in_colour(s_tdata[3+2*CW +: 27]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // Hold the result until the transaction completes
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res <= res;
  end

  assign m_tdata = {3'd0, out_res.iterations, out_res.root_found, out_res.converged,
                    out_res.blue, out_res.green, out_res.red};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the Newton fractal pixel unit: directed table, then random phases.
module testbench;
  import nfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 3000;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [47:0] re;
    logic [47:0] im;
    logic [8:0]  wr;
    logic [8:0]  wg;
    logic [8:0]  wb;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  newton_fractal_pixel_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow state of the unit
  cfg_t        cfg;
  longint      root_re [8];
  longint      root_im [8];
  logic [26:0] colour_tab [8];

  res_t expected_pixels [$];
  int   errors;
  int   idle_mode;
  int   n_points;
  int   n_loads;
  int   n_checked;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint clamp_diff(longint z, longint a);
    longint d;
    d = z - a;
    if (d > longint'(DIFF_LIMIT)) return longint'(DIFF_LIMIT);
    if (d < -longint'(DIFF_LIMIT)) return -longint'(DIFF_LIMIT);
    return d;
  endfunction

  function automatic longint clamp_coord(longint z, longint w);
    longint r;
    r = z - w;
    if (r > 64'sd140737488355327) return 64'sd140737488355327;
    if (r < -64'sd140737488355328) return -64'sd140737488355328;
    return r;
  endfunction

  // floor(a*b*2^sh / den), truncated to 128 bits before the divide, then capped
  function automatic longint scaled_div(logic [63:0] a, logic [63:0] b, int sh,
                                        logic [127:0] den, logic [63:0] cap, bit neg);
    logic [127:0] num;
    logic [127:0] quo;
    num = (128'(a) * 128'(b)) << sh;
    quo = num / den;
    if (quo > 128'(cap)) quo = 128'(cap);
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic logic [63:0] shade_scale(logic [63:0] n);
    logic [63:0] f;
    logic [63:0] mf;
    logic [63:0] g;
    logic [63:0] base;
    logic [63:0] s;
    f  = cfg.fade_steps == 0 ? 64'd1 : 64'(cfg.fade_steps);
    mf = cfg.min_fade > 17'd65536 ? 64'd65536 : 64'(cfg.min_fade);
    if (cfg.cyclic_mode) begin
      g = ((f - n % f) << 32) / f;
    end else begin
      base = ((f - 1) << 32) / f;
      g = 64'd1 << 32;
      while (n != 0) begin
        if (n[0]) g = (g * base) >> 32;
        base = (base * base) >> 32;
        n = n >> 1;
      end
    end
    g = (mf << 16) + (((64'd65536 - mf) * g) >> 16);
    s = g << 8;
    if (s > (64'd255 << 32)) s = 64'd255 << 32;
    return s;
  endfunction

  function automatic logic [7:0] channel_level(logic [8:0] w, logic [63:0] s);
    logic [63:0] c;
    c = (64'(w) * s) >> 40;
    return c > 255 ? 8'd255 : c[7:0];
  endfunction

  function automatic res_t predict_pixel(logic [47:0] re, logic [47:0] im);
    res_t        r;
    longint      zr;
    longint      zi;
    longint      dr;
    longint      di;
    longint      u;
    longint      v;
    logic [127:0] m;
    logic [127:0] q;
    logic [63:0] pm;
    logic [63:0] count;
    logic [63:0] s;
    logic [26:0] entry;
    bit          pneg;
    bit          conv;
    int          rc;
    int          cc;
    int          root;
    rc = cfg.root_count > 8 ? 8 : int'(cfg.root_count);
    cc = cfg.colour_count > 8 ? 8 : int'(cfg.colour_count);
    if (cc == 0) cc = 1;
    zr = longint'(signed'(re));
    zi = longint'(signed'(im));
    pm = mag(longint'(cfg.power));
    pneg = cfg.power < 0;
    conv = 0;
    root = 0;
    count = 0;
    while (1) begin
      dr = 0;
      di = 0;
      for (int k = 0; k < rc; k++) begin
        u = clamp_diff(zr, root_re[k]);
        v = clamp_diff(zi, root_im[k]);
        m = 128'(mag(u)) * 128'(mag(u)) + 128'(mag(v)) * 128'(mag(v));
        if (m < 128'(TOL_Q80)) begin
          conv = 1;
          root = k;
          break;
        end
        dr += scaled_div(pm, mag(u), TERM_SHIFT, m, 64'(TERM_CAP), pneg != (u < 0));
        di += scaled_div(pm, mag(v), TERM_SHIFT, m, 64'(TERM_CAP), pneg == (v < 0));
      end
      if (conv) break;
      q = 128'(mag(dr)) * 128'(mag(dr)) + 128'(mag(di)) * 128'(mag(di));
      if (q == 0) begin
        count = 64'(cfg.iteration_limit) + 1;
        break;
      end
      zr = clamp_coord(zr, scaled_div(1, mag(dr), STEP_SHIFT, q, 64'(STEP_CAP), dr < 0));
      zi = clamp_coord(zi, scaled_div(1, mag(di), STEP_SHIFT, q, 64'(STEP_CAP), di > 0));
      count++;
      if (count > 64'(cfg.iteration_limit)) break;
    end
    entry = colour_tab[conv ? root % cc : cc - 1];
    s = shade_scale(count);
    r.red        = channel_level(entry[8:0], s);
    r.green      = channel_level(entry[17:9], s);
    r.blue       = channel_level(entry[26:18], s);
    r.converged  = conv;
    r.root_found = conv ? 3'(root) : 3'd0;
    r.iterations = count[16:0];
    return r;
  endfunction

  // Present one item and wait for its transaction; update shadow tables on acceptance
  task automatic send_item(logic [1:0] op, logic [2:0] slot, logic [47:0] re, logic [47:0] im,
                           logic [8:0] wr, logic [8:0] wg, logic [8:0] wb,
                           bit typed, res_t want);
    int gap;
    int pct;
    gap = 0;
    pct = idle_mode == 1 ? 88 : (idle_mode == 3 ? 27 : 0);
    while (int'($urandom_range(0, 99)) < pct && gap < 200) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, wb, wg, wr, im, re, slot};
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_POINT: begin
        expected_pixels.push_back(typed ? want : predict_pixel(re, im));
        n_points++;
      end
      OP_ROOT: begin
        root_re[slot] = longint'(signed'(re));
        root_im[slot] = longint'(signed'(im));
        n_loads++;
      end
      OP_COLOUR: begin
        colour_tab[slot] = {wb, wg, wr};
        n_loads++;
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROOT_COUNT:   cfg.root_count      = value[3:0];
      REG_COLOUR_COUNT: cfg.colour_count    = value[3:0];
      REG_ITER_LIMIT:   cfg.iteration_limit = value[15:0];
      REG_FADE_STEPS:   cfg.fade_steps      = value[15:0];
      REG_MIN_FADE:     cfg.min_fade        = value[16:0];
      REG_POWER:        cfg.power           = value[23:0];
      REG_CYCLIC_MODE:  cfg.cyclic_mode     = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_pixels.size() > 0) @(posedge clk);
    // a load may still be in work
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [47:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return rand48();
      default: return 48'(longint'($urandom_range(0, 32'hFFFFFFFF)) * 512
                          - 64'sd2199023255552);
    endcase
  endfunction

  task automatic random_item();
    logic [47:0] re;
    logic [47:0] im;
    int          k;
    int          j;
    int          sel;
    res_t        none;
    none = '0;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      send_item(OP_ROOT, 3'($urandom), rand_coord(), rand_coord(), 9'($urandom),
                9'($urandom), 9'($urandom), 0, none);
    end else if (sel < 50) begin
      send_item(OP_COLOUR, 3'($urandom), rand48(), rand48(),
                $urandom_range(0, 3) == 0 ? 9'd256 : 9'($urandom_range(0, 511)),
                9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 0, none);
    end else if (sel < 95) begin
      k = $urandom_range(0, 7);
      j = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          re = 48'(root_re[k] + (longint'($urandom) >>> $urandom_range(0, 31)) - 64'sd1073741824);
          im = 48'(root_im[k] + (longint'($urandom) >>> $urandom_range(0, 31)) - 64'sd1073741824);
        end
        5: begin
          // halfway between two roots: terms may cancel
          re = 48'((root_re[k] + root_re[j]) >>> 1);
          im = 48'((root_im[k] + root_im[j]) >>> 1);
        end
        6: begin
          re = 48'(root_re[k]);
          im = 48'(root_im[k]);
        end
        default: begin
          re = rand_coord();
          im = rand_coord();
        end
      endcase
      send_item(OP_POINT, 3'($urandom), re, im, 9'($urandom), 9'($urandom), 9'($urandom),
                0, none);
    end else begin
      send_item(2'd3, 3'($urandom), rand48(), rand48(), 9'($urandom), 9'($urandom),
                9'($urandom), 0, none);
    end
  endtask

  task automatic setup_phase(int ph);
    cfg_t c;
    c.root_count      = $urandom_range(0, 9) < 8 ? 4'($urandom_range(1, 3)) : 4'($urandom);
    c.colour_count    = 4'($urandom);
    c.iteration_limit = 16'($urandom_range(1, 6));
    case ($urandom_range(0, 3))
      0:       c.fade_steps = 16'd0;
      1:       c.fade_steps = 16'($urandom_range(1, 20));
      2:       c.fade_steps = 16'($urandom);
      default: c.fade_steps = 16'd1;
    endcase
    c.min_fade = $urandom_range(0, 7) == 0 ? 17'h1FFFF : 17'($urandom_range(0, 70000));
    if ($urandom_range(0, 3) == 0) c.power = 24'($urandom);
    else c.power = 24'(int'($urandom_range(1, 4)) * 65536 * ($urandom_range(0, 1) ? 1 : -1));
    c.cyclic_mode = 1'($urandom);
    case (ph)
      1: c = '{4'd0, 4'd0, 16'd65535, 16'd0, 17'd0, 24'sd65536, 1'b0};
      2: c = '{4'd8, 4'd15, 16'd65535, 16'd65535, 17'd65536, 24'sd0, 1'b1};
      3: c = '{4'd15, 4'd3, 16'd1, 16'd1, 17'h1FFFF, -24'sd8388608, 1'b0};
      4: c = '{4'd1, 4'd1, 16'd4, 16'd65535, 17'd0, 24'sd8388607, 1'b1};
      default: ;
    endcase
    write_reg(REG_ROOT_COUNT,   32'(c.root_count));
    write_reg(REG_COLOUR_COUNT, 32'(c.colour_count));
    write_reg(REG_ITER_LIMIT,   32'(c.iteration_limit));
    write_reg(REG_FADE_STEPS,   32'(c.fade_steps));
    write_reg(REG_MIN_FADE,     32'(c.min_fade));
    write_reg(REG_POWER,        32'(unsigned'(c.power)));
    write_reg(REG_CYCLIC_MODE,  32'(c.cyclic_mode));
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    if (idle_mode == 2) m_tready <= $urandom_range(0, 99) >= 88;
    else if (idle_mode == 3) m_tready <= $urandom_range(0, 99) >= 27;
    else m_tready <= 1'b1;
  end

  // Result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[44:0]);
      if (expected_pixels.size() == 0) begin
        $error("result with no pending pixel: %h", m_tdata);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        n_checked++;
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          errors++;
        end
        if (got.converged !== want.converged) begin
          $error("converged: expected %0d, got %0d", want.converged, got.converged);
          errors++;
        end
        if (got.root_found !== want.root_found) begin
          $error("root_found: expected %0d, got %0d", want.root_found, got.root_found);
          errors++;
        end
        if (got.iterations !== want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, got.iterations);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir [23];
    res_t      none;
    none = '0;
    // roots: origin, +1, -1, +i, -i, (0.5,0.5), both extremes
    dir[0]  = '{OP_ROOT, 3'd0, 48'd0, 48'd0, 9'd0, 9'd0, 9'd0, 0, none};
    dir[1]  = '{OP_ROOT, 3'd1, 48'h010000000000, 48'd0, 9'd0, 9'd0, 9'd0, 0, none};
    dir[2]  = '{OP_ROOT, 3'd2, 48'hFF0000000000, 48'd0, 9'd0, 9'd0, 9'd0, 0, none};
    dir[3]  = '{OP_ROOT, 3'd3, 48'd0, 48'h010000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[4]  = '{OP_ROOT, 3'd4, 48'd0, 48'hFF0000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[5]  = '{OP_ROOT, 3'd5, 48'h008000000000, 48'h008000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[6]  = '{OP_ROOT, 3'd6, 48'h800000000000, 48'h800000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[7]  = '{OP_ROOT, 3'd7, 48'h7FFFFFFFFFFF, 48'h7FFFFFFFFFFF, 9'd0, 9'd0, 9'd0, 0, none};
    dir[8]  = '{OP_COLOUR, 3'd0, 48'd0, 48'd0, 9'd256, 9'd0, 9'd511, 0, none};
    dir[9]  = '{OP_COLOUR, 3'd1, 48'd0, 48'd0, 9'd0, 9'd256, 9'd0, 0, none};
    dir[10] = '{OP_COLOUR, 3'd2, 48'd0, 48'd0, 9'd511, 9'd511, 9'd511, 0, none};
    dir[11] = '{OP_COLOUR, 3'd3, 48'd0, 48'd0, 9'd128, 9'd64, 9'd32, 0, none};
    dir[12] = '{OP_COLOUR, 3'd4, 48'd0, 48'd0, 9'd1, 9'd2, 9'd4, 0, none};
    dir[13] = '{OP_COLOUR, 3'd5, 48'd0, 48'd0, 9'd255, 9'd257, 9'd0, 0, none};
    dir[14] = '{OP_COLOUR, 3'd6, 48'd0, 48'd0, 9'd256, 9'd256, 9'd256, 0, none};
    dir[15] = '{OP_COLOUR, 3'd7, 48'd0, 48'd0, 9'd300, 9'd100, 9'd200, 0, none};
    // point on the root: no steps, full brightness, red and blue saturate
    dir[16] = '{OP_POINT, 3'd0, 48'd0, 48'd0, 9'd0, 9'd0, 9'd0, 1,
                res_t'{17'd0, 3'd0, 1'b1, 8'd255, 8'd0, 8'd255}};
    dir[17] = '{OP_POINT, 3'd7, 48'h7FFFFFFFFFFF, 48'h7FFFFFFFFFFF, 9'h1FF, 9'h1FF, 9'h1FF,
                0, none};
    dir[18] = '{OP_POINT, 3'd0, 48'h800000000000, 48'h800000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[19] = '{OP_POINT, 3'd0, 48'h010000000000, 48'hFF0000000000, 9'd0, 9'd0, 9'd0, 0, none};
    dir[20] = '{OP_POINT, 3'd0, 48'h000000000001, 48'd0, 9'd0, 9'd0, 9'd0, 0, none};
    dir[21] = '{2'd3, 3'd7, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 9'h1FF, 9'h1FF, 9'h1FF,
                0, none};
    dir[22] = '{OP_POINT, 3'd0, 48'h000040000000, 48'h5A5A5A5A5A5A, 9'd0, 9'd0, 9'd0, 0, none};

    errors = 0;
    n_points = 0;
    n_loads = 0;
    n_checked = 0;
    quiet_cycles = 0;
    idle_mode = 0;
    cfg = '{RST_ROOT_COUNT, RST_COLOUR_COUNT, RST_ITER_LIMIT, RST_FADE_STEPS,
            RST_MIN_FADE, RST_POWER, RST_CYCLIC_MODE};
    for (int i = 0; i < 8; i++) begin
      root_re[i] = 0;
      root_im[i] = 0;
      colour_tab[i] = '0;
    end
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir[i])
      send_item(dir[i].op, dir[i].slot, dir[i].re, dir[i].im, dir[i].wr, dir[i].wg, dir[i].wb,
                dir[i].typed, dir[i].want);

    for (int ph = 1; ph <= PHASES; ph++) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      wait_idle();
      setup_phase(ph);
      idle_mode = ph % 4;
      repeat (ITEMS_PER_PHASE) random_item();
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_idle();

    $display("covered %0d pixels and %0d table loads over %0d register settings",
             n_points, n_loads, PHASES + 1);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0 && expected_pixels.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/nfp_pkg.sv
hdl/nfp_mul.sv
hdl/nfp_div.sv
hdl/nfp_core.sv
hdl/newton_fractal_pixel_unit.sv
sim/testbench.sv
